// ===== hw/rtl/three_phase_sample_rms_normalizer_core_defines.svh =====
// Assertion macros for the three-phase RMS normalizer
`ifndef THREE_PHASE_SAMPLE_RMS_NORMALIZER_CORE_DEFINES_SVH
`define THREE_PHASE_SAMPLE_RMS_NORMALIZER_CORE_DEFINES_SVH

// clocked implication check, disabled in reset
`define TPRN_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication check, disabled in reset
`define TPRN_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/tprn_pkg.sv =====
// Package: types, constants and commands for the three-phase RMS normalizer
package tprn_pkg;

    localparam int WINDOW_DEF = 400;
    localparam int CNT_W = 12;
    localparam int NCFG = 8;
    localparam int CFG_IDX_W = 3;
    localparam int DATA_W = 24;
    localparam int CODE_W = 16;
    localparam int SUM_W = 64;
    localparam int QMAX = 8388607;
    localparam int DAC_SCALE = 2000;
    localparam int DAC_OFFS = 2048 * 4096;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN_VOLT_A = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_VOLT_B = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_VOLT_C = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_AMP_A = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_AMP_B = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_AMP_C = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_INV_VOLT = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_INV_AMP = 3'd7;

    localparam logic [DATA_W-1:0] CFG_RESET [NCFG] = '{
        24'd1046856, 24'd1052087, 24'd1052006, 24'd178474,
        24'd184388, 24'd178012, 24'd16777215, 24'd16777215
    };

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PHYS,
        ST_NORM,
        ST_DAC,
        ST_OUT0,
        ST_ROOT_LD,
        ST_SQRT,
        ST_OUT1
    } state_t;

    typedef struct packed {
        logic       load;
        logic       phys_step;
        logic       norm_step;
        logic       dac_step;
        logic       sqrt_start;
        logic       sqrt_step;
        logic       rms_store;
        logic       clear_sums;
        logic [2:0] chan;
    } cmd_t;

    typedef struct packed {
        logic sqrt_done;
        logic window_done;
    } stat_t;

endpackage

// ===== hw/rtl/tprn_datapath.sv =====
// Datapath: gain multiply, accumulators, normalizer and windowed square root
module tprn_datapath #(
    parameter int WINDOW = tprn_pkg::WINDOW_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic [6*tprn_pkg::CODE_W-1:0]           in_data,
    input  logic [tprn_pkg::DATA_W-1:0]             cfg [tprn_pkg::NCFG],
    input  tprn_pkg::cmd_t                          cmd,
    output tprn_pkg::stat_t                         stat,
    output logic [6*tprn_pkg::DATA_W-1:0]           norm_flat,
    output logic [6*tprn_pkg::DATA_W-1:0]           rms_flat,
    output logic [11:0]                             dac
);
    localparam int DW = tprn_pkg::DATA_W;
    localparam int SW = tprn_pkg::SUM_W;
    localparam int CW = tprn_pkg::CNT_W;

    logic signed [15:0] code_reg [6];
    logic signed [DW-1:0] phys_reg [6];
    logic signed [DW-1:0] norm_reg [6];
    logic [DW-1:0] rms_reg [6];
    logic [SW-1:0] sum_reg [6];
    logic [CW-1:0] cnt_reg;
    logic [11:0] dac_reg;

    logic signed [16:0] x;
    logic signed [42:0] prod;
    logic signed [42:0] rnd;
    logic signed [26:0] shf;
    logic signed [DW-1:0] phys_sat;
    logic signed [48:0] nprod;
    logic signed [24:0] nshf;
    logic signed [DW-1:0] norm_sat;
    logic signed [47:0] sq;
    logic signed [36:0] dt;
    logic [CW:0] cnt_inc;
    logic win_hit;

    // root of sum / WINDOW: largest r with WINDOW * r^2 <= sum, one bit a step;
    // trial term WINDOW * 2^k * (2r + 2^k) is kept as sa + sb
    logic [SW-1:0] srem_reg, sa_reg, sb_reg;
    logic [SW-1:0] strial;
    logic [DW-1:0] sroot_reg;
    logic [4:0] scnt_reg;
    logic stake;

    always_comb
    begin
        case (cmd.chan)
            3'd0: x = 17'(code_reg[1]) - 17'(code_reg[5]);
            3'd1: x = 17'(code_reg[3]) - 17'(code_reg[1]);
            3'd2: x = 17'(code_reg[5]) - 17'(code_reg[3]);
            3'd3: x = 17'(code_reg[0]);
            3'd4: x = 17'(code_reg[2]);
            default: x = 17'(code_reg[4]);
        endcase
        prod = 43'(x) * $signed({19'd0, cfg[cmd.chan]});
        rnd = prod + 43'sd32768;
        shf = rnd[42:16];
        if (shf > 27'sd8388607)
            phys_sat = 24'sh7FFFFF;
        else if (shf < -27'sd8388608)
            phys_sat = 24'sh800000;
        else
            phys_sat = shf[DW-1:0];
        nprod = 49'(phys_reg[cmd.chan])
              * $signed({25'd0, cfg[(cmd.chan < 3'd3) ? tprn_pkg::REG_INV_VOLT
                                                      : tprn_pkg::REG_INV_AMP]})
              + 49'sd8388608;
        nshf = nprod[48:24];
        norm_sat = (nshf > 25'sd8388607) ? 24'sh7FFFFF : nshf[DW-1:0];
        sq = 48'(phys_reg[cmd.chan]) * 48'(phys_reg[cmd.chan]);
        dt = 37'(norm_reg[0]) * 37'(tprn_pkg::DAC_SCALE) + 37'(tprn_pkg::DAC_OFFS);
        cnt_inc = {1'b0, cnt_reg} + 1'b1;
        win_hit = (cnt_inc >= (CW+1)'(WINDOW));
        strial = sa_reg + sb_reg;
        stake = (srem_reg >= strial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
                sum_reg[i] <= '0;
            cnt_reg <= '0;
            srem_reg <= '0;
            sa_reg <= '0;
            sb_reg <= '0;
            sroot_reg <= '0;
            scnt_reg <= '0;
        end
        else
        begin
            if (cmd.load)
                for (int i = 0; i < 6; i++)
                    code_reg[i] <= in_data[16*i +: 16];
            if (cmd.phys_step)
                phys_reg[cmd.chan] <= phys_sat;
            if (cmd.norm_step)
            begin
                norm_reg[cmd.chan] <= norm_sat;
                sum_reg[cmd.chan] <= sum_reg[cmd.chan] + SW'($unsigned(sq));
            end
            if (cmd.dac_step)
            begin
                if (dt < 0)
                    dac_reg <= '0;
                else if (dt[36:12] > 25'd4095)
                    dac_reg <= 12'hFFF;
                else
                    dac_reg <= dt[23:12];
                if (win_hit)
                    cnt_reg <= '0;
                else
                    cnt_reg <= cnt_inc[CW-1:0];
            end
            if (cmd.sqrt_start)
            begin
                srem_reg <= sum_reg[cmd.chan];
                sa_reg <= '0;
                sb_reg <= SW'(WINDOW) << (2 * (DW - 1));
                sroot_reg <= '0;
                scnt_reg <= '0;
            end
            else if (cmd.sqrt_step)
            begin
                if (stake)
                begin
                    srem_reg <= srem_reg - strial;
                    sa_reg <= (sa_reg >> 1) + sb_reg;
                end
                else
                    sa_reg <= sa_reg >> 1;
                sb_reg <= sb_reg >> 2;
                sroot_reg <= {sroot_reg[DW-2:0], stake};
                scnt_reg <= scnt_reg + 1'b1;
            end
            if (cmd.rms_store)
                rms_reg[cmd.chan] <= (sroot_reg > DW'(tprn_pkg::QMAX)) ?
                    DW'(tprn_pkg::QMAX) : sroot_reg;
            if (cmd.clear_sums)
            begin
                for (int i = 0; i < 6; i++)
                    sum_reg[i] <= '0;
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            norm_flat[DW*i +: DW] = norm_reg[i];
            rms_flat[DW*i +: DW] = rms_reg[i];
        end
        dac = dac_reg;
        stat.sqrt_done = (scnt_reg == 5'(DW));
        stat.window_done = win_hit;
    end

endmodule

// ===== hw/rtl/tprn_ctrl.sv =====
// Controller: sequences channels and root steps, drives output handshakes
`include "three_phase_sample_rms_normalizer_core_defines.svh"
module tprn_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_fire,
    input  logic            out_fire,
    input  tprn_pkg::stat_t stat,
    output tprn_pkg::cmd_t  cmd,
    output logic            busy,
    output logic            out_valid,
    output logic            out_kind,
    output logic            out_last_sel
);
    tprn_pkg::state_t state_reg, state_next;
    logic [2:0] chan_reg, chan_next;
    logic win_reg, win_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tprn_pkg::ST_IDLE;
            chan_reg <= '0;
            win_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            chan_reg <= chan_next;
            win_reg <= win_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        chan_next = chan_reg;
        win_next = win_reg;
        cmd = '0;
        cmd.chan = chan_reg;
        out_valid = 1'b0;
        out_kind = 1'b0;
        out_last_sel = 1'b0;
        busy = 1'b1;
        case (state_reg)
            tprn_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (in_fire)
                begin
                    cmd.load = 1'b1;
                    chan_next = '0;
                    state_next = tprn_pkg::ST_PHYS;
                end
            end
            tprn_pkg::ST_PHYS:
            begin
                cmd.phys_step = 1'b1;
                state_next = tprn_pkg::ST_NORM;
            end
            tprn_pkg::ST_NORM:
            begin
                cmd.norm_step = 1'b1;
                if (chan_reg == 3'd5)
                begin
                    chan_next = '0;
                    state_next = tprn_pkg::ST_DAC;
                end
                else
                begin
                    chan_next = chan_reg + 1'b1;
                    state_next = tprn_pkg::ST_PHYS;
                end
            end
            tprn_pkg::ST_DAC:
            begin
                cmd.dac_step = 1'b1;
                win_next = stat.window_done;
                state_next = tprn_pkg::ST_OUT0;
            end
            tprn_pkg::ST_OUT0:
            begin
                out_valid = 1'b1;
                out_last_sel = !win_reg;
                if (out_fire)
                begin
                    if (win_reg)
                    begin
                        chan_next = '0;
                        state_next = tprn_pkg::ST_ROOT_LD;
                    end
                    else
                        state_next = tprn_pkg::ST_IDLE;
                end
            end
            tprn_pkg::ST_ROOT_LD:
            begin
                cmd.sqrt_start = 1'b1;
                state_next = tprn_pkg::ST_SQRT;
            end
            tprn_pkg::ST_SQRT:
            begin
                if (stat.sqrt_done)
                begin
                    cmd.rms_store = 1'b1;
                    if (chan_reg == 3'd5)
                    begin
                        cmd.clear_sums = 1'b1;
                        state_next = tprn_pkg::ST_OUT1;
                    end
                    else
                    begin
                        chan_next = chan_reg + 1'b1;
                        state_next = tprn_pkg::ST_ROOT_LD;
                    end
                end
                else
                    cmd.sqrt_step = 1'b1;
            end
            tprn_pkg::ST_OUT1:
            begin
                out_valid = 1'b1;
                out_kind = 1'b1;
                out_last_sel = 1'b1;
                if (out_fire)
                    state_next = tprn_pkg::ST_IDLE;
            end
            default:
                state_next = tprn_pkg::ST_IDLE;
        endcase
    end

    `TPRN_ASSERT_IMP(a_in_idle, clk, rst_n, in_fire, state_reg == tprn_pkg::ST_IDLE,
        "word accepted while busy")
    `TPRN_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_fire, out_valid,
        "result dropped before taken")
    `TPRN_ASSERT_IMP(a_rms_last, clk, rst_n, out_valid && out_kind, out_last_sel,
        "rms word not marked last")
endmodule

// ===== hw/rtl/three_phase_sample_rms_normalizer_core.sv =====
// Three-phase sampler: every sample word yields one normalized word with its DAC code,
// valid once six gain/normalize channel pairs and one DAC step have run; the next word
// is taken only after the normalized word has been taken. Every WINDOW-th sample adds
// an RMS word once the normalized word is taken: each of six channels runs a load and
// a 24-step square root that folds the divide by WINDOW into its trial subtraction.
// The input is taken only when the block is idle, and output stalls hold the block.
module three_phase_sample_rms_normalizer_core #(
    parameter int WINDOW = tprn_pkg::WINDOW_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // amp_a_code, volt_ab_code, amp_b_code, volt_bc_code, amp_c_code, volt_ca_code
    input  logic [95:0]  s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // val_volt_a, val_volt_b, val_volt_c, val_amp_a, val_amp_b, val_amp_c, dac_code
    output logic [159:0] m_tdata,
    // kind
    output logic         m_tuser,
    output logic         m_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);
    logic [tprn_pkg::DATA_W-1:0] cfg_reg [tprn_pkg::NCFG];
    tprn_pkg::cmd_t cmd;
    tprn_pkg::stat_t stat;
    logic busy, kind, last_sel;
    logic [143:0] norm_flat, rms_flat;
    logic [11:0] dac;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            for (int i = 0; i < tprn_pkg::NCFG; i++)
                cfg_reg[i] <= tprn_pkg::CFG_RESET[i];
        else if (cfg_valid)
            cfg_reg[cfg_index] <= cfg_data[tprn_pkg::DATA_W-1:0];
    end

    assign s_tready = !busy;

    tprn_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_fire(s_tvalid && s_tready),
        .out_fire(m_tvalid && m_tready),
        .stat(stat), .cmd(cmd), .busy(busy),
        .out_valid(m_tvalid), .out_kind(kind), .out_last_sel(last_sel)
    );

    tprn_datapath #(.WINDOW(WINDOW)) u_dp (
        .clk(clk), .rst_n(rst_n), .in_data(s_tdata), .cfg(cfg_reg),
        .cmd(cmd), .stat(stat), .norm_flat(norm_flat), .rms_flat(rms_flat),
        .dac(dac)
    );

    assign m_tuser = kind;
    assign m_tlast = last_sel;
    assign m_tdata = kind ? {4'd0, 12'd0, rms_flat} : {4'd0, dac, norm_flat};
endmodule

// ===== tb/three_phase_sample_rms_normalizer_core_tb.sv =====
// Self-checking testbench for the three-phase sample normalizer with windowed RMS
module three_phase_sample_rms_normalizer_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIN = tprn_pkg::WINDOW_DEF;
    localparam int LIMIT_CYCLES = 4000000;

    typedef struct packed {
        logic        kind;
        logic [23:0] va, vb, vc, ia, ib, ic;
        logic [11:0] dac;
        logic        last;
    } word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [95:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [159:0] m_tdata;
    logic m_tuser;
    logic m_tlast;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    logic [23:0] gain_regs [tprn_pkg::NCFG];
    logic [63:0] sq_sums [6];
    int sample_cnt;
    word_t expected_words [$];
    int errors = 0;
    int samples_sent = 0;
    int rms_seen = 0;
    int cycles = 0;

    three_phase_sample_rms_normalizer_core u_top (.*);

    initial begin
        forever #2 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // output stall generator
    initial begin
        int n;
        forever begin
            @(posedge clk);
            if ($urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                n = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 300)
                                                 : $urandom_range(1, 4);
                repeat (n) @(posedge clk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(0, 30)) @(posedge clk);
        end
    end

    function automatic logic signed [23:0] sat24(logic signed [63:0] v);
        if (v > 64'sd8388607) return 24'sh7FFFFF;
        if (v < -64'sd8388608) return 24'sh800000;
        return v[23:0];
    endfunction

    function automatic logic signed [23:0] gain_round(logic signed [63:0] x,
                                                      logic [23:0] k, int s);
        logic signed [63:0] p;
        p = x * $signed({40'd0, k}) + (64'sd1 <<< (s - 1));
        return sat24(p >>> s);
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] n);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    task automatic predict_sample(logic [95:0] d);
        logic signed [15:0] c [6];
        logic signed [23:0] phys [6];
        logic signed [23:0] norm [6];
        logic signed [63:0] t;
        logic [63:0] m;
        word_t w;
        bit done;
        for (int i = 0; i < 6; i++) c[i] = d[16*i +: 16];
        phys[0] = gain_round(64'(c[1]) - 64'(c[5]),
                             gain_regs[tprn_pkg::REG_GAIN_VOLT_A], 16);
        phys[1] = gain_round(64'(c[3]) - 64'(c[1]),
                             gain_regs[tprn_pkg::REG_GAIN_VOLT_B], 16);
        phys[2] = gain_round(64'(c[5]) - 64'(c[3]),
                             gain_regs[tprn_pkg::REG_GAIN_VOLT_C], 16);
        phys[3] = gain_round(64'(c[0]), gain_regs[tprn_pkg::REG_GAIN_AMP_A], 16);
        phys[4] = gain_round(64'(c[2]), gain_regs[tprn_pkg::REG_GAIN_AMP_B], 16);
        phys[5] = gain_round(64'(c[4]), gain_regs[tprn_pkg::REG_GAIN_AMP_C], 16);
        for (int i = 0; i < 6; i++) begin
            sq_sums[i] += 64'(64'(phys[i]) * 64'(phys[i]));
            norm[i] = gain_round(64'(phys[i]),
                                 gain_regs[i < 3 ? tprn_pkg::REG_INV_VOLT
                                                 : tprn_pkg::REG_INV_AMP], 24);
        end
        t = 64'(norm[0]) * 2000 + 64'sd8388608;
        done = (sample_cnt + 1 >= WIN);
        w.kind = 1'b0;
        {w.va, w.vb, w.vc, w.ia, w.ib, w.ic} =
            {norm[0], norm[1], norm[2], norm[3], norm[4], norm[5]};
        if (t < 0) w.dac = 12'd0;
        else if ((t >>> 12) > 4095) w.dac = 12'd4095;
        else w.dac = t[23:12];
        w.last = !done;
        expected_words.push_back(w);
        if (!done) begin
            sample_cnt++;
            return;
        end
        for (int i = 0; i < 6; i++) begin
            m = int_sqrt(sq_sums[i] / WIN);
            if (m > 64'd8388607) m = 64'd8388607;
            norm[i] = m[23:0];
            sq_sums[i] = 0;
        end
        w.kind = 1'b1;
        {w.va, w.vb, w.vc, w.ia, w.ib, w.ic} =
            {norm[0], norm[1], norm[2], norm[3], norm[4], norm[5]};
        w.dac = 12'd0;
        w.last = 1'b1;
        expected_words.push_back(w);
        sample_cnt = 0;
    endtask

    // result checker
    always @(posedge clk) begin
        word_t got, exp_w;
        if (rst_n && m_tvalid && m_tready) begin
            got = {m_tuser, m_tdata[23:0], m_tdata[47:24], m_tdata[71:48],
                   m_tdata[95:72], m_tdata[119:96], m_tdata[143:120],
                   m_tdata[155:144], m_tlast};
            if (expected_words.size() == 0) begin
                $error("unexpected word %h", got);
                errors++;
            end else begin
                exp_w = expected_words.pop_front();
                if (got.kind) rms_seen++;
                if (got.kind !== exp_w.kind) begin
                    $error("kind exp %h got %h", exp_w.kind, got.kind); errors++;
                end
                if (got.va !== exp_w.va) begin
                    $error("val_volt_a exp %h got %h", exp_w.va, got.va); errors++;
                end
                if (got.vb !== exp_w.vb) begin
                    $error("val_volt_b exp %h got %h", exp_w.vb, got.vb); errors++;
                end
                if (got.vc !== exp_w.vc) begin
                    $error("val_volt_c exp %h got %h", exp_w.vc, got.vc); errors++;
                end
                if (got.ia !== exp_w.ia) begin
                    $error("val_amp_a exp %h got %h", exp_w.ia, got.ia); errors++;
                end
                if (got.ib !== exp_w.ib) begin
                    $error("val_amp_b exp %h got %h", exp_w.ib, got.ib); errors++;
                end
                if (got.ic !== exp_w.ic) begin
                    $error("val_amp_c exp %h got %h", exp_w.ic, got.ic); errors++;
                end
                if (got.dac !== exp_w.dac) begin
                    $error("dac_code exp %h got %h", exp_w.dac, got.dac); errors++;
                end
                if (got.last !== exp_w.last) begin
                    $error("last exp %h got %h", exp_w.last, got.last); errors++;
                end
            end
        end
    end

    task automatic send_sample(logic [95:0] d);
        int gap;
        gap = ($urandom_range(0, 20) == 0) ? $urandom_range(10, 200)
                                           : $urandom_range(0, 3);
        if ($urandom_range(0, 3) == 0) gap = 0;
        repeat (gap) @(posedge clk);
        s_tvalid <= 1'b1;
        s_tdata <= d;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        predict_sample(d);
        samples_sent++;
        s_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain_results();
        while (expected_words.size() != 0) @(posedge clk);
        repeat (700) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        gain_regs[idx] = val[23:0];
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_all(logic [23:0] gv, logic [23:0] gi, logic [23:0] iv,
                             logic [23:0] ii);
        drain_results();
        write_reg(tprn_pkg::REG_GAIN_VOLT_A, {8'hA5, gv});
        write_reg(tprn_pkg::REG_GAIN_VOLT_B, {8'h00, gv ^ 24'h000100});
        write_reg(tprn_pkg::REG_GAIN_VOLT_C, {8'hFF, gv});
        write_reg(tprn_pkg::REG_GAIN_AMP_A, {8'h00, gi});
        write_reg(tprn_pkg::REG_GAIN_AMP_B, {8'h3C, gi ^ 24'h000010});
        write_reg(tprn_pkg::REG_GAIN_AMP_C, {8'h00, gi});
        write_reg(tprn_pkg::REG_INV_VOLT, {8'h00, iv});
        write_reg(tprn_pkg::REG_INV_AMP, {8'h00, ii});
    endtask

    function automatic logic [95:0] rand_sample(int mode);
        logic [95:0] d;
        for (int i = 0; i < 6; i++) begin
            case (mode)
                0: d[16*i +: 16] = 16'($urandom);
                1: d[16*i +: 16] = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
                default: d[16*i +: 16] = 16'($signed($urandom_range(0, 2000)) - 1000);
            endcase
        end
        return d;
    endfunction

    task automatic test_directed_extremes();
        send_sample('0);
        send_sample({6{16'h7FFF}});
        send_sample({6{16'h8000}});
        send_sample({16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF});
        send_sample({16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000});
        send_sample({16'h0001, 16'hFFFF, 16'h0001, 16'hFFFF, 16'h0001, 16'hFFFF});
        send_sample({16'h1234, 16'h8000, 16'hEDCB, 16'h0000, 16'h4000, 16'h7FFF});
    endtask

    task automatic test_zero_and_max_config();
        write_all(24'd0, 24'd0, 24'd0, 24'd0);
        send_sample({6{16'h7FFF}});
        send_sample(rand_sample(0));
        write_all(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        send_sample({6{16'h7FFF}});
        send_sample({6{16'h8000}});
        send_sample({16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF});
        send_sample(rand_sample(0));
        drain_results();
        write_reg(tprn_pkg::REG_INV_AMP, 32'hFFFFFFFF);
    endtask

    task automatic test_window(int n, int mode);
        for (int i = 0; i < n; i++) begin
            send_sample(rand_sample(($urandom_range(0, 9) == 0) ? 0 : mode));
            if (i == n / 2) drain_results();
        end
    endtask

    initial begin
        for (int i = 0; i < tprn_pkg::NCFG; i++) gain_regs[i] = tprn_pkg::CFG_RESET[i];
        for (int i = 0; i < 6; i++) sq_sums[i] = 0;
        sample_cnt = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_extremes();
        test_window(WIN, 2);
        test_zero_and_max_config();
        write_all(24'd1046856, 24'd178474, 24'd8388608, 24'd4194304);
        test_window(WIN + 40, 0);
        drain_results();
        $display("covered %0d samples, %0d RMS windows, reset/zero/full/mid gains",
                 samples_sent, rms_seen);
        if (errors == 0) $display("[ OK ] regression clean");
        else $display("[FAIL] regression broken");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/tprn_pkg.sv
hw/rtl/tprn_datapath.sv
hw/rtl/tprn_ctrl.sv
hw/rtl/three_phase_sample_rms_normalizer_core.sv
tb/three_phase_sample_rms_normalizer_core_tb.sv
